>>> design/nfi_pkg.sv
// Shared constants, types and elaboration-time functions of the NTT core.
// Holds the modulus, the Barrett reciprocal and the twiddle table; no dependencies.
package nfi_pkg;

	localparam int COEF_W          = 30;
	localparam int POS_W           = 6;
	localparam int LOG_W           = 3;
	localparam int CFG_IDX_W       = 2;
	localparam int DEF_MAX_POINTS  = 64;
	localparam int TW_DEPTH        = 64;
	localparam int TW_IDX_W        = 6;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LOG_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 2'd1;

	localparam logic [63:0] PRIME_MOD  = 64'd998244353;
	localparam logic [63:0] ROOT_GEN   = 64'd3;
	localparam logic [63:0] MU64       = (64'd1 << 60) / PRIME_MOD;
	localparam logic [30:0] BARRETT_MU = MU64[30:0];
	localparam logic [31:0] P32        = PRIME_MOD[31:0];
	localparam logic [31:0] P32X2      = 32'(PRIME_MOD * 64'd2);

	typedef logic [COEF_W-1:0] tw_table_t [TW_DEPTH];

	function automatic logic [63:0] const_mod_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b) % PRIME_MOD;
	endfunction

	function automatic logic [63:0] const_mod_pow(input logic [63:0] base, input logic [63:0] e);
		logic [63:0] r;
		logic [63:0] bb;
		logic [63:0] ee;
		r  = 64'd1;
		bb = base % PRIME_MOD;
		ee = e;
		for (int t = 0; t < 64; t++) begin
			if (ee[0]) r = const_mod_mul(r, bb);
			bb = const_mod_mul(bb, bb);
			ee = ee >> 1;
		end
		return r;
	endfunction

	// entry half+j holds w_(2*half)^j
	function automatic tw_table_t gen_twiddles();
		tw_table_t   tab;
		logic [63:0] w [TW_DEPTH];
		logic [63:0] e;
		for (int i = 0; i < TW_DEPTH; i++) w[i] = 64'd0;
		w[1] = 64'd1;
		for (int k = 1; (1 << k) < TW_DEPTH; k++) begin
			e = const_mod_pow(ROOT_GEN, (PRIME_MOD - 64'd1) >> (k + 1));
			for (int i = (1 << (k - 1)); i < (1 << k); i++) begin
				w[2 * i]     = w[i];
				w[2 * i + 1] = const_mod_mul(w[i], e);
			end
		end
		for (int i = 0; i < TW_DEPTH; i++) tab[i] = w[i][COEF_W-1:0];
		return tab;
	endfunction

	localparam tw_table_t TWIDDLES = gen_twiddles();

endpackage

>>> design/nfi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module nfi_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> design/ntt_forward_inverse_core.sv
// Radix-2 NTT core modulo 998244353, forward or inverse over N = 2^L points.
// Depends on nfi_pkg and nfi_ram.
//
// Usage: write log_length (index 0) and inverse_mode (index 1) while the core
// is idle, then present N coefficients one per start pulse (start is taken
// when busy is low). After the N-th word busy goes high and the core runs
// (N/2)*L butterflies: one memory read port feeds u and v in turn, the
// modular multiplier is a three stage Barrett pipeline, and the single write
// port stores both results. Results then leave in natural order, forward
// directly or inverse after the scaling goes back through the multiplier.
// Each result is shown for one cycle with strobe high and cannot be held
// off; final_res marks the last one. A write to log_length drops a partial
// load.
module ntt_forward_inverse_core
	import nfi_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [LOG_W-1:0]     wr_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [COEF_W-1:0]    coefficient,
	output logic                 strobe,
	output logic [COEF_W-1:0]    value,
	output logic [POS_W-1:0]     position,
	output logic                 final_res
);

	localparam int AW   = $clog2(MAX_POINTS);
	localparam int MAXL = $clog2(MAX_POINTS + 1) - 1;

	localparam logic [3:0] S_LOAD = 4'd0;
	localparam logic [3:0] S_RDU  = 4'd1;
	localparam logic [3:0] S_RDV  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_M1   = 4'd4;
	localparam logic [3:0] S_M2   = 4'd5;
	localparam logic [3:0] S_WU   = 4'd6;
	localparam logic [3:0] S_WV   = 4'd7;
	localparam logic [3:0] S_ORD  = 4'd8;
	localparam logic [3:0] S_OMUL = 4'd9;
	localparam logic [3:0] S_OM1  = 4'd10;
	localparam logic [3:0] S_OM2  = 4'd11;
	localparam logic [3:0] S_OEM  = 4'd12;

	logic [3:0]        state_q;
	logic [LOG_W-1:0]  log_length_q;
	logic              inverse_mode_q;
	logic [AW:0]       cnt_q;
	logic [LOG_W-1:0]  lg_q;        // log2 of the length of the running transform
	logic              inv_q;       // mode sampled at load end
	logic [COEF_W-1:0] ninv_q;
	logic [LOG_W-1:0]  stg_q;       // butterfly stage, span 2^stg
	logic [AW-1:0]     bf_q;        // butterfly within the stage
	logic [AW-1:0]     out_q;       // output element
	logic [COEF_W-1:0] u_q;
	logic [COEF_W-1:0] diff_q;

	// strobe and payload of the result word
	logic              strobe_q;
	logic [COEF_W-1:0] value_q;
	logic [POS_W-1:0]  position_q;
	logic              final_q;

	// length decode
	logic [LOG_W-1:0] lg_eff;
	logic [AW:0]      n_eff;
	logic [AW:0]      n_run;

	always_comb begin
		priority if (log_length_q == '0)                lg_eff = LOG_W'(1);
		else if (log_length_q > LOG_W'(MAXL))          lg_eff = LOG_W'(MAXL);
		else                                           lg_eff = log_length_q;
	end
	assign n_eff = (AW+1)'(1) << lg_eff;
	assign n_run = (AW+1)'(1) << lg_q;

	// butterfly addressing
	logic [AW-1:0]       half;
	logic [AW-1:0]       jj;
	logic [AW-1:0]       top;
	logic [AW-1:0]       bot;
	logic [TW_IDX_W-1:0] tw_idx;
	logic [COEF_W-1:0]   tw;

	assign half   = AW'(1) << stg_q;
	assign jj     = bf_q & (half - AW'(1));
	assign top    = ((bf_q >> stg_q) << (stg_q + LOG_W'(1))) | jj;
	assign bot    = top | half;
	assign tw_idx = TW_IDX_W'(half | jj);
	assign tw     = TWIDDLES[tw_idx];

	// first stage reads the load memory through bit reversal (and the
	// index negation mod N of inverse mode), so the permutation costs no pass
	function automatic logic [AW-1:0] perm_addr(input logic [AW-1:0] x,
			input logic [LOG_W-1:0] lg, input logic inv, input logic [AW:0] n);
		logic [AW-1:0] rv;
		logic [AW-1:0] br;
		for (int t = 0; t < AW; t++) rv[t] = x[AW-1-t];
		br = rv >> (LOG_W'(AW) - lg);
		if (inv) return AW'((n - {1'b0, br}) & (n - (AW+1)'(1)));
		return br;
	endfunction

	// memories
	logic              a_we;
	logic [AW-1:0]     a_raddr;
	logic [COEF_W-1:0] a_rdata;
	logic              b_we;
	logic [AW-1:0]     b_waddr;
	logic [COEF_W-1:0] b_wdata;
	logic [AW-1:0]     b_raddr;
	logic [COEF_W-1:0] b_rdata;
	logic [COEF_W-1:0] rd_sel;
	logic [AW-1:0]     rd_x;

	assign a_we = start && !busy;

	always_comb begin
		unique case (state_q)
			S_RDV:   rd_x = bot;
			S_ORD:   rd_x = out_q;
			default: rd_x = top;
		endcase
	end
	assign a_raddr = perm_addr(rd_x, lg_q, inv_q, n_run);
	assign b_raddr = rd_x;

	// stage select of the read data is registered with the read itself
	logic rd_from_a_q;
	assign rd_sel = rd_from_a_q ? a_rdata : b_rdata;

	nfi_ram #(.WIDTH(COEF_W), .DEPTH(MAX_POINTS)) u_load_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (coefficient),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	nfi_ram #(.WIDTH(COEF_W), .DEPTH(MAX_POINTS)) u_work_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// Barrett multiplier: product, quotient estimate, remainder, then
	// at most two subtractions of p
	logic [COEF_W-1:0] mul_b;
	logic [59:0]       prod_s1;
	logic [61:0]       qt_s2;
	logic [31:0]       plo_s2;
	logic [31:0]       r_s3;
	logic [30:0]       q_est;
	logic [31:0]       qp;
	logic [COEF_W-1:0] red;

	assign mul_b = (state_q == S_OMUL) ? ninv_q : tw;
	assign q_est = qt_s2[61:31];
	assign qp    = 32'({1'b0, q_est} * P32);

	always_ff @(posedge clk) begin
		prod_s1 <= 60'(rd_sel) * 60'(mul_b);
		qt_s2   <= 62'(prod_s1[59:29]) * 62'(BARRETT_MU);
		plo_s2  <= prod_s1[31:0];
		r_s3    <= plo_s2 - qp;
	end

	always_comb begin
		priority if (r_s3 >= P32X2) red = COEF_W'(r_s3 - P32X2);
		else if (r_s3 >= P32)       red = COEF_W'(r_s3 - P32);
		else                        red = r_s3[COEF_W-1:0];
	end

	// butterfly add and subtract, one conditional subtraction each
	logic [31:0]       sum_w;
	logic [31:0]       dif_w;
	logic [COEF_W-1:0] sum_r;
	logic [COEF_W-1:0] dif_r;

	assign sum_w = 32'(u_q) + 32'(red);
	assign dif_w = 32'(u_q) + P32 - 32'(red);
	assign sum_r = (sum_w >= P32) ? COEF_W'(sum_w - P32) : sum_w[COEF_W-1:0];
	assign dif_r = (dif_w >= P32) ? COEF_W'(dif_w - P32) : dif_w[COEF_W-1:0];

	always_comb begin
		b_we    = 1'b0;
		b_waddr = top;
		b_wdata = sum_r;
		unique case (state_q)
			S_WU: b_we = 1'b1;
			S_WV: begin
				b_we    = 1'b1;
				b_waddr = bot;
				b_wdata = diff_q;
			end
			default: b_we = 1'b0;
		endcase
	end

	assign busy = (state_q != S_LOAD);

	logic last_bf;
	logic last_out;
	assign last_bf  = ({1'b0, bf_q} == (n_run >> 1) - (AW+1)'(1));
	assign last_out = ({1'b0, out_q} == n_run - (AW+1)'(1));

	always_ff @(posedge clk) begin
		if (state_q == S_RDV) u_q <= rd_sel;
		if (state_q == S_WU)  diff_q <= dif_r;
		if (state_q == S_RDU || state_q == S_RDV) rd_from_a_q <= (stg_q == '0);
		if (state_q == S_ORD) rd_from_a_q <= 1'b0;
		// result payload
		if (state_q == S_OMUL && !inv_q) value_q <= rd_sel;
		if (state_q == S_OEM)            value_q <= red;
		if (state_q == S_OMUL || state_q == S_OEM) begin
			position_q <= POS_W'(out_q);
			final_q    <= last_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			log_length_q   <= LOG_W'(6);
			inverse_mode_q <= 1'b0;
			cnt_q          <= '0;
			lg_q           <= LOG_W'(1);
			inv_q          <= 1'b0;
			ninv_q         <= '0;
			stg_q          <= '0;
			bf_q           <= '0;
			out_q          <= '0;
			strobe_q       <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (wr_en) begin
				if (wr_index == REG_LOG_LENGTH) begin
					log_length_q <= wr_data;
					cnt_q        <= '0;
				end else if (wr_index == REG_INVERSE_MODE) begin
					inverse_mode_q <= wr_data[0];
				end
			end
			unique case (state_q)
				S_LOAD: begin
					if (start) begin
						if (cnt_q + (AW+1)'(1) == n_eff) begin
							cnt_q   <= '0;
							lg_q    <= lg_eff;
							inv_q   <= inverse_mode_q;
							ninv_q  <= COEF_W'(PRIME_MOD - ((PRIME_MOD - 64'd1) >> lg_eff));
							stg_q   <= '0;
							bf_q    <= '0;
							out_q   <= '0;
							state_q <= S_RDU;
						end else begin
							cnt_q <= cnt_q + (AW+1)'(1);
						end
					end
				end
				S_RDU: state_q <= S_RDV;
				S_RDV: state_q <= S_MUL;
				S_MUL: state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_WU;
				S_WU:  state_q <= S_WV;
				S_WV: begin
					if (last_bf) begin
						bf_q <= '0;
						if (stg_q == lg_q - LOG_W'(1)) state_q <= S_ORD;
						else begin
							stg_q   <= stg_q + LOG_W'(1);
							state_q <= S_RDU;
						end
					end else begin
						bf_q    <= bf_q + AW'(1);
						state_q <= S_RDU;
					end
				end
				S_ORD: state_q <= S_OMUL;
				S_OMUL: begin
					if (inv_q) state_q <= S_OM1;
					else begin
						strobe_q <= 1'b1;
						out_q    <= out_q + AW'(1);
						state_q  <= last_out ? S_LOAD : S_ORD;
					end
				end
				S_OM1: state_q <= S_OM2;
				S_OM2: state_q <= S_OEM;
				S_OEM: begin
					strobe_q <= 1'b1;
					out_q    <= out_q + AW'(1);
					state_q  <= last_out ? S_LOAD : S_ORD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign value     = value_q;
	assign position  = position_q;
	assign final_res = final_q;

endmodule
